@@ sv/swlc_pkg.sv @@
// Shared constants, codes and control structs for the L1 cache unit.
package swlc_pkg;

  localparam int WAYS       = 4;
  localparam int SETS       = 64;
  localparam int LINE_WORDS = 16;

  localparam int WAY_W   = $clog2(WAYS);
  localparam int SET_W   = $clog2(SETS);
  localparam int WORD_W  = $clog2(LINE_WORDS);
  localparam int OFF_W   = WORD_W + 2;
  localparam int TAG_W   = 32 - SET_W - OFF_W;
  localparam int LI_W    = WAY_W + SET_W;
  localparam int DATA_AW = LI_W + WORD_W;

  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 2;

  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_INVAL = 3'd2;
  localparam logic [2:0] OP_CLEAN = 3'd3;
  localparam logic [2:0] OP_FILL  = 3'd4;

  localparam logic [2:0] K_READ  = 3'd0;
  localparam logic [2:0] K_WDONE = 3'd1;
  localparam logic [2:0] K_BURST = 3'd2;
  localparam logic [2:0] K_REQ   = 3'd3;
  localparam logic [2:0] K_STORE = 3'd4;
  localparam logic [2:0] K_MAINT = 3'd5;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;
  localparam logic [1:0] SZ_BAD  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WBM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IC  = 2'd2;

  localparam logic [31:0] BYTE_MASK = 32'hFF;
  localparam logic [31:0] HALF_MASK = 32'hFFFF;

  typedef enum logic [3:0] {
    E_NONE, E_BAD, E_READ, E_WSTORE, E_WDONE, E_BURST, E_CLEAN, E_REQ, E_MDONE
  } emit_t;

  typedef struct packed {
    logic  latch;
    logic  fill_step;
    logic  fill_done;
    logic  take;
    logic  vp_adv;
    logic  inval;
    logic  clean;
    logic  store;
    logic  set_pend;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  rd_fin;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       size_bad;
    logic       pend;
    logic       fill_last;
    logic       hit;
    logic       is_read;
    logic       evict_wb;
    logic       inval_wb;
    logic       clean_go;
    logic       cnt_last;
    logic       cnt_dirty;
    logic       out_free;
    logic       fwd;
  } stat_t;

endpackage

@@ sv/swlc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module swlc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/swlc_dp.sv @@
// Cache datapath: tag, dirty, data and victim stores, pending miss, result register.
module swlc_dp import swlc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic                   cfg_wdata,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [2:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [2:0]             m_tuser,
  output logic                   m_tlast
);

  logic [2:0]        in_op;
  logic [31:0]       in_addr, in_data, in_fword;
  logic [1:0]        in_size;
  logic [SET_W-1:0]  in_mset;
  logic [WAY_W-1:0]  in_mway;

  logic cfg_wbm, cfg_fwd, cfg_ic;

  logic              pend_valid, pend_op;
  logic [31:0]       pend_addr, pend_data;
  logic [1:0]        pend_size;
  logic [WAY_W-1:0]  pend_way;
  logic [WORD_W-1:0] fill_count;

  logic [WAY_W-1:0]      cur_way;
  logic [SET_W-1:0]      cur_set;
  logic [TAG_W-1:0]      cur_tag;
  logic                  cur_valid, cur_hit;
  logic [LINE_WORDS-1:0] cur_dirty;
  logic [WORD_W-1:0]     cnt;

  logic [WAYS-1:0] valid [SETS];
  logic [SETS-1:0] vp_ok;

  logic [SET_W-1:0]      look_set, pend_set;
  logic [TAG_W-1:0]      look_tag, pend_tag;
  logic [TAG_W-1:0]      tag_rd [WAYS];
  logic [LINE_WORDS-1:0] dirty_rd [WAYS];
  logic [WAY_W-1:0]      vp_rd, vp_way, vp_nxt, hit_way, sel_way;
  logic                  hit;
  logic [WORD_W-1:0]     word_idx;
  logic [31:0]           data_rd, mask, rd_val, store_word;
  logic [4:0]            sh;
  logic                  data_we;
  logic [DATA_AW-1:0]    data_waddr, data_raddr;
  logic [31:0]           data_wdata;
  logic [LINE_WORDS-1:0] dirty_wdata;
  logic [SET_W-1:0]      dirty_waddr;

  logic [2:0]  o_kind;
  logic [31:0] o_addr, o_data;
  logic [1:0]  o_size;
  logic        o_hit, o_last;

  assign look_set = in_op[1] ? in_mset : in_addr[OFF_W +: SET_W];
  assign look_tag = in_addr[31 -: TAG_W];
  assign pend_set = pend_addr[OFF_W +: SET_W];
  assign pend_tag = pend_addr[31 -: TAG_W];
  assign word_idx = in_addr[2 +: WORD_W];

  assign dirty_waddr = cmd.fill_done ? pend_set : cur_set;
  assign dirty_wdata = cmd.store ? (cur_dirty | (LINE_WORDS'(1) << word_idx)) : '0;

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    logic dirty_we;
    assign dirty_we = (cmd.fill_done && pend_way == WAY_W'(w)) ||
                      ((cmd.inval || cmd.clean || (cmd.store && cfg_wbm)) &&
                       cur_way == WAY_W'(w));
    swlc_ram #(.WIDTH(TAG_W), .DEPTH(SETS)) u_tag (
      .clk(clk), .we(cmd.fill_done && pend_way == WAY_W'(w)), .waddr(pend_set),
      .wdata(pend_tag), .raddr(look_set), .rdata(tag_rd[w])
    );
    swlc_ram #(.WIDTH(LINE_WORDS), .DEPTH(SETS)) u_dirty (
      .clk(clk), .we(dirty_we), .waddr(dirty_waddr), .wdata(dirty_wdata),
      .raddr(look_set), .rdata(dirty_rd[w])
    );
  end

  assign vp_way = vp_ok[look_set] ? vp_rd : '0;
  assign vp_nxt = (vp_way == WAY_W'(WAYS - 1)) ? '0 : vp_way + 1'b1;

  swlc_ram #(.WIDTH(WAY_W), .DEPTH(SETS)) u_vp (
    .clk(clk), .we(cmd.vp_adv), .waddr(look_set), .wdata(vp_nxt),
    .raddr(look_set), .rdata(vp_rd)
  );

  // lowest matching way wins
  always_comb begin
    hit = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid[look_set][w] && tag_rd[w] == look_tag) begin
        hit = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  assign sel_way = in_op[1] ? in_mway : (hit ? hit_way : vp_way);

  always_comb begin
    case (in_size)
      SZ_BYTE: begin
        sh = {in_addr[1:0], 3'b000};
        mask = BYTE_MASK;
      end
      SZ_HALF: begin
        sh = {in_addr[1], 4'b0000};
        mask = HALF_MASK;
      end
      default: begin
        sh = '0;
        mask = '1;
      end
    endcase
  end

  assign rd_val = (data_rd >> sh) & mask;
  assign store_word = (data_rd & ~(mask << sh)) | ((in_data & mask) << sh);

  assign data_we = cmd.fill_step || cmd.store;
  assign data_waddr = cmd.fill_step ? {pend_way, pend_set, fill_count}
                                    : {cur_way, cur_set, word_idx};
  assign data_wdata = cmd.fill_step ? in_fword : store_word;
  assign data_raddr = {cur_way, cur_set, cmd.rd_fin ? word_idx : cnt};

  swlc_ram #(.WIDTH(32), .DEPTH(WAYS * SETS * LINE_WORDS)) u_data (
    .clk(clk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
    .raddr(data_raddr), .rdata(data_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_wbm <= 1'b1;
      cfg_fwd <= 1'b1;
      cfg_ic <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WBM) cfg_wbm <= cfg_wdata;
      if (cfg_index == CFG_FWD) cfg_fwd <= cfg_wdata;
      if (cfg_index == CFG_IC) cfg_ic <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_op <= s_tuser;
      in_addr <= s_tdata[31:0];
      in_data <= s_tdata[63:32];
      in_size <= s_tdata[65:64];
      in_mset <= s_tdata[71:66];
      in_mway <= s_tdata[73:72];
      in_fword <= s_tdata[105:74];
    end else if (cmd.fill_done) begin
      in_op <= {2'b00, pend_op};
      in_addr <= pend_addr;
      in_data <= pend_data;
      in_size <= pend_size;
    end
    if (cmd.take) begin
      cur_way <= sel_way;
      cur_set <= look_set;
      cur_tag <= tag_rd[sel_way];
      cur_valid <= valid[look_set][sel_way];
      cur_dirty <= valid[look_set][sel_way] ? dirty_rd[sel_way] : '0;
      cur_hit <= hit;
    end else if (cmd.fill_done) begin
      cur_way <= pend_way;
      cur_set <= pend_set;
      cur_dirty <= '0;
      cur_hit <= 1'b0;
    end
    if (cmd.set_pend) begin
      pend_op <= in_op[0];
      pend_addr <= in_addr;
      pend_data <= in_data;
      pend_size <= in_size;
      pend_way <= cur_way;
    end
    if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      fill_count <= '0;
      vp_ok <= '0;
      for (int s = 0; s < SETS; s++) valid[s] <= '0;
    end else begin
      if (cmd.set_pend) pend_valid <= 1'b1;
      else if (cmd.fill_done) pend_valid <= 1'b0;
      if (cmd.set_pend || cmd.fill_done) fill_count <= '0;
      else if (cmd.fill_step) fill_count <= fill_count + 1'b1;
      if (cmd.vp_adv) vp_ok[look_set] <= 1'b1;
      if (cmd.fill_done) valid[pend_set][pend_way] <= 1'b1;
      else if (cmd.inval) valid[cur_set][cur_way] <= 1'b0;
    end
  end

  always_comb begin
    o_kind = K_MAINT;
    o_addr = '0;
    o_data = '0;
    o_size = SZ_BYTE;
    o_hit = 1'b0;
    o_last = 1'b1;
    case (cmd.emit)
      E_BAD: begin
        o_kind = in_op;
        o_addr = in_addr;
      end
      E_READ: begin
        o_kind = K_READ;
        o_addr = in_addr;
        o_data = rd_val;
        o_hit = cur_hit;
      end
      E_WSTORE: begin
        o_kind = K_STORE;
        o_addr = in_addr;
        o_data = in_data & mask;
        o_size = in_size;
        o_last = 1'b0;
      end
      E_WDONE: begin
        o_kind = K_WDONE;
        o_addr = in_addr;
        o_hit = cur_hit;
      end
      E_BURST: begin
        o_kind = K_BURST;
        o_addr = {cur_tag, cur_set, cnt, 2'b00};
        o_data = data_rd;
        o_last = 1'b0;
      end
      E_CLEAN: begin
        o_kind = K_STORE;
        o_addr = {cur_tag, cur_set, cnt, 2'b00};
        o_data = data_rd;
        o_size = SZ_WORD;
        o_last = 1'b0;
      end
      E_REQ: begin
        o_kind = K_REQ;
        o_addr = {in_addr[31:OFF_W], OFF_W'(0)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit != E_NONE) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.emit != E_NONE) begin
      m_tdata <= {5'b00000, o_hit, o_size, o_data, o_addr};
      m_tuser <= o_kind;
      m_tlast <= o_last;
    end
  end

  always_comb begin
    stat.op = in_op;
    stat.size_bad = in_size == SZ_BAD;
    stat.pend = pend_valid;
    stat.fill_last = fill_count == WORD_W'(LINE_WORDS - 1);
    stat.hit = hit;
    stat.is_read = in_op == OP_READ;
    stat.evict_wb = cur_valid && (cur_dirty != '0) && cfg_wbm;
    stat.inval_wb = cur_valid && (cur_dirty != '0) && cfg_wbm && !cfg_ic;
    stat.clean_go = cur_valid && cfg_wbm;
    stat.cnt_last = cnt == WORD_W'(LINE_WORDS - 1);
    stat.cnt_dirty = cur_dirty[cnt];
    stat.out_free = !m_tvalid || m_tready;
    stat.fwd = cfg_fwd;
  end

endmodule

@@ sv/swlc_ctrl.sv @@
// Cache controller: sequences lookup, eviction, fill, maintenance and results.
module swlc_ctrl import swlc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    IDLE, DEC, BAD, EVAL, MISS, MAINT, BRD, BOUT, CRD, COUT, REQ, MDONE,
    FIN_RD, FIN, WDONE
  } state_t;

  state_t state, state_next;
  logic   access;

  assign s_tready = state == IDLE;
  assign access = stat.op == OP_READ || stat.op == OP_WRITE;

  always_comb begin
    cmd = '0;
    cmd.emit = E_NONE;
    state_next = state;
    case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.latch = 1'b1;
          state_next = DEC;
        end
      end
      DEC: begin
        if (stat.op == OP_FILL) begin
          state_next = IDLE;
          if (stat.pend) begin
            cmd.fill_step = 1'b1;
            if (stat.fill_last) begin
              cmd.fill_done = 1'b1;
              state_next = FIN_RD;
            end
          end
        end else if (stat.op > OP_FILL || stat.pend) begin
          state_next = IDLE;
        end else if (access && stat.size_bad) begin
          state_next = BAD;
        end else begin
          state_next = EVAL;
        end
      end
      BAD: begin
        if (stat.out_free) begin
          cmd.emit = E_BAD;
          state_next = IDLE;
        end
      end
      EVAL: begin
        cmd.take = 1'b1;
        if (!access) begin
          state_next = MAINT;
        end else if (stat.hit) begin
          state_next = FIN_RD;
        end else begin
          cmd.vp_adv = 1'b1;
          state_next = MISS;
        end
      end
      MISS: begin
        cmd.inval = 1'b1;
        cmd.set_pend = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_next = stat.evict_wb ? BRD : REQ;
      end
      MAINT: begin
        cmd.cnt_clr = 1'b1;
        state_next = MDONE;
        if (stat.op == OP_INVAL) begin
          cmd.inval = 1'b1;
          if (stat.inval_wb) state_next = BRD;
        end else if (stat.clean_go) begin
          cmd.clean = 1'b1;
          state_next = CRD;
        end
      end
      BRD: state_next = BOUT;
      BOUT: begin
        if (stat.out_free) begin
          cmd.emit = E_BURST;
          cmd.cnt_inc = 1'b1;
          if (!stat.cnt_last) state_next = BRD;
          else if (access) state_next = REQ;
          else state_next = MDONE;
        end
      end
      CRD: state_next = COUT;
      COUT: begin
        if (!stat.cnt_dirty || stat.out_free) begin
          if (stat.cnt_dirty) cmd.emit = E_CLEAN;
          cmd.cnt_inc = 1'b1;
          state_next = stat.cnt_last ? MDONE : CRD;
        end
      end
      REQ: begin
        if (stat.out_free) begin
          cmd.emit = E_REQ;
          state_next = IDLE;
        end
      end
      MDONE: begin
        if (stat.out_free) begin
          cmd.emit = E_MDONE;
          state_next = IDLE;
        end
      end
      FIN_RD: begin
        cmd.rd_fin = 1'b1;
        state_next = FIN;
      end
      FIN: begin
        cmd.rd_fin = 1'b1;
        if (stat.out_free) begin
          if (stat.is_read) begin
            cmd.emit = E_READ;
            state_next = IDLE;
          end else begin
            cmd.store = 1'b1;
            if (stat.fwd) begin
              cmd.emit = E_WSTORE;
              state_next = WDONE;
            end else begin
              cmd.emit = E_WDONE;
              state_next = IDLE;
            end
          end
        end
      end
      WDONE: begin
        if (stat.out_free) begin
          cmd.emit = E_WDONE;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/set_assoc_writeback_l1_cache_unit.sv @@
// Top level of the 4-way, 64-set write-back L1 cache with round-robin victims.
// One item at a time. A hit passes DEC, EVAL, FIN_RD and FIN before its result
// is registered; a forwarded store adds WDONE. A miss passes DEC, EVAL, MISS,
// BRD and BOUT per written-back word, then REQ. Fill words pass DEC; the last
// goes on through FIN_RD and FIN. Output stalls hold the output states.
// Synchronous reset clears valid bits, victim pointers and pending miss, and resets config.
module set_assoc_writeback_l1_cache_unit import swlc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic                   cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // address, write_data, access_size, line_set, line_way, fill_word
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // op
  input  logic [2:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // out_address, out_data, out_size, was_hit
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // kind
  output logic [2:0]             m_tuser,
  output logic                   m_tlast
);

  cmd_t  cmd;
  stat_t stat;

  swlc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .stat(stat), .cmd(cmd)
  );

  swlc_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while another is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit != E_NONE |-> stat.out_free)
    else $error("result register overwritten");

  a_single_miss: assert property (@(posedge clk) disable iff (rst)
    cmd.set_pend |-> !stat.pend)
    else $error("second miss while a fill is pending");

  a_fill_done: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_done |-> stat.pend && stat.fill_last)
    else $error("fill completed without a full line");

endmodule

@@ tb/set_assoc_writeback_l1_cache_unit_tb.sv @@
// Self-checking testbench for the set-associative write-back L1 cache unit.
`timescale 1ns / 100ps

module set_assoc_writeback_l1_cache_unit_tb;
  import swlc_pkg::*;

  localparam int LINE_BYTES = LINE_WORDS * 4;
  localparam int NLINES     = WAYS * SETS;

  class cache_scoreboard;
    typedef struct {
      bit [2:0]  kind;
      bit [31:0] addr;
      bit [31:0] data;
      bit [1:0]  size;
      bit        hit;
      bit        last;
    } result_t;

    bit [31:0] tags[NLINES];
    bit        valid[NLINES];
    bit [15:0] dirty[NLINES];
    bit [31:0] words[NLINES * LINE_WORDS];
    bit [1:0]  victim[SETS];
    bit        miss_pending;
    bit [2:0]  p_op;
    bit [31:0] p_addr, p_data, p_tag;
    bit [1:0]  p_size;
    int        p_way, p_set, fills;
    bit        wb_mode = 1, fwd_mode = 1, icache = 0;
    result_t   expected_q[$];
    int        errors;

    function void push(bit [2:0] k, bit [31:0] a, bit [31:0] d, bit [1:0] s, bit h);
      result_t r;
      r.kind = k; r.addr = a; r.data = d; r.size = s; r.hit = h; r.last = 0;
      expected_q.push_back(r);
    endfunction

    function bit [31:0] base_of(int li, int st);
      bit [63:0] a;
      a = ({32'd0, tags[li]} * SETS + st) * LINE_BYTES;
      return a[31:0];
    endfunction

    function void write_back_line(int li, int st);
      bit [31:0] b;
      b = base_of(li, st);
      for (int i = 0; i < LINE_WORDS; i++)
        push(K_BURST, b + 4 * i, words[li * LINE_WORDS + i], 0, 0);
    endfunction

    function void complete(bit [2:0] op, bit [31:0] a, bit [31:0] d, bit [1:0] s,
                           int li, bit h);
      int wi, idx, sh;
      bit [31:0] m;
      wi = (a % LINE_BYTES) / 4;
      idx = li * LINE_WORDS + wi;
      if (s == SZ_BYTE) begin
        sh = 8 * (a & 3); m = BYTE_MASK;
      end else if (s == SZ_HALF) begin
        sh = 8 * (a & 2); m = HALF_MASK;
      end else begin
        sh = 0; m = 32'hFFFF_FFFF;
      end
      if (op == OP_READ) begin
        push(K_READ, a, (words[idx] >> sh) & m, 0, h);
        return;
      end
      words[idx] = (words[idx] & ~(m << sh)) | ((d & m) << sh);
      if (wb_mode) dirty[li][wi] = 1;
      if (fwd_mode) push(K_STORE, a, d & m, s, 0);
      push(K_WDONE, a, 0, 0, h);
    endfunction

    function void note_item(bit [2:0] op, bit [31:0] a, bit [31:0] d, bit [1:0] s,
                            bit [5:0] mset, bit [1:0] mway, bit [31:0] fw);
      int n0, li, st, way;
      bit [31:0] lnum, tg, b;
      bit h;
      n0 = expected_q.size();
      if (op == OP_FILL) begin
        if (!miss_pending) return;
        li = p_way * SETS + p_set;
        if (fills < LINE_WORDS) words[li * LINE_WORDS + fills] = fw;
        fills++;
        if (fills < LINE_WORDS) return;
        tags[li] = p_tag; valid[li] = 1; dirty[li] = 0;
        miss_pending = 0; fills = 0;
        complete(p_op, p_addr, p_data, p_size, li, 0);
      end else if (op > OP_FILL || miss_pending) begin
        return;
      end else if (op <= OP_WRITE) begin
        if (s == SZ_BAD) begin
          push(op, a, 0, 0, 0);
        end else begin
          lnum = a / LINE_BYTES;
          st = lnum % SETS;
          tg = lnum / SETS;
          h = 0;
          for (way = 0; way < WAYS; way++)
            if (valid[way * SETS + st] && tags[way * SETS + st] == tg) begin
              h = 1;
              break;
            end
          if (h) begin
            complete(op, a, d, s, way * SETS + st, 1);
          end else begin
            way = victim[st];
            victim[st] = victim[st] + 1;
            li = way * SETS + st;
            if (valid[li] && dirty[li] != 0 && wb_mode) write_back_line(li, st);
            valid[li] = 0; dirty[li] = 0;
            push(K_REQ, a - a % LINE_BYTES, 0, 0, 0);
            miss_pending = 1;
            p_op = op; p_addr = a; p_data = d; p_size = s;
            p_way = way; p_set = st; p_tag = tg; fills = 0;
          end
        end
      end else begin
        li = mway * SETS + mset;
        if (op == OP_INVAL) begin
          if (valid[li] && dirty[li] != 0 && wb_mode && !icache) write_back_line(li, mset);
          valid[li] = 0; dirty[li] = 0;
        end else if (valid[li] && wb_mode) begin
          b = base_of(li, mset);
          for (int i = 0; i < LINE_WORDS; i++)
            if (dirty[li][i]) push(K_STORE, b + 4 * i, words[li * LINE_WORDS + i], SZ_WORD, 0);
          dirty[li] = 0;
        end
        push(K_MAINT, 0, 0, 0, 0);
      end
      if (expected_q.size() > n0) expected_q[expected_q.size() - 1].last = 1;
    endfunction

    function void check_result(bit [2:0] k, bit [31:0] a, bit [31:0] d, bit [1:0] s,
                               bit h, bit l);
      result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected item: kind %0d addr %h", k, a);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (k != e.kind) begin $error("kind: exp %0d got %0d", e.kind, k); errors++; end
      if (a != e.addr) begin $error("out_address: exp %h got %h", e.addr, a); errors++; end
      if (d != e.data) begin $error("out_data: exp %h got %h", e.data, d); errors++; end
      if (s != e.size) begin $error("out_size: exp %0d got %0d", e.size, s); errors++; end
      if (h != e.hit) begin $error("was_hit: exp %0d got %0d", e.hit, h); errors++; end
      if (l != e.last) begin $error("last: exp %0d got %0d", e.last, l); errors++; end
    endfunction
  endclass

  logic                   clk = 0;
  logic                   rst = 1;
  logic                   cfg_we = 0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic                   cfg_wdata = 0;
  logic                   s_tvalid = 0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [2:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [2:0]             m_tuser;
  logic                   m_tlast;

  cache_scoreboard sb = new();
  int burst_left;
  int counted;

  set_assoc_writeback_l1_cache_unit u_dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    #30ms;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[65:64],
                      m_tdata[66], m_tlast);

  int rx_cyc, rx_mode;
  always @(negedge clk) begin
    rx_cyc++;
    if (rx_cyc % 300 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: m_tready <= 1;
      1: m_tready <= ($urandom_range(0, 9) < 7);
      2: m_tready <= (rx_cyc % 4 == 0);
      default: m_tready <= ((rx_cyc / 8) % 2 == 0);
    endcase
  end

  task automatic send_item(bit [2:0] op, bit [31:0] a, bit [31:0] d, bit [1:0] s,
                           bit [5:0] mset, bit [1:0] mway, bit [31:0] fw);
    if (burst_left <= 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1;
    s_tuser  <= op;
    s_tdata  <= {6'd0, fw, mway, mset, s, d, a};
    do @(posedge clk); while (!s_tready);
    sb.note_item(op, a, d, s, mset, mway, fw);
    if (op <= OP_FILL) counted++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_cfg(bit [CFG_IDX_W-1:0] idx, bit v);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == CFG_WBM) sb.wb_mode = v;
    else if (idx == CFG_FWD) sb.fwd_mode = v;
    else sb.icache = v;
  endtask

  task automatic fill_line(bit noisy);
    for (int i = 0; i < LINE_WORDS; i++) begin
      if (noisy && $urandom_range(0, 15) == 0)
        send_item(3'($urandom_range(0, 3)), $urandom, $urandom, 2'($urandom_range(0, 3)),
                  6'($urandom), 2'($urandom), $urandom);
      send_item(OP_FILL, $urandom, $urandom, 2'($urandom), 6'($urandom), 2'($urandom),
                $urandom);
    end
  endtask

  function automatic bit [31:0] pick_addr();
    bit [31:0] tg;
    if ($urandom_range(0, 9) >= 8) return $urandom;
    case ($urandom_range(0, 4))
      0: tg = 0;
      1: tg = 1;
      2: tg = 2;
      3: tg = 3;
      default: tg = 32'hFFFFF;
    endcase
    return (tg << 12) | ($urandom_range(0, 3) << 6) | $urandom_range(0, 63);
  endfunction

  task automatic access(bit [2:0] op, bit [31:0] a, bit [1:0] s);
    send_item(op, a, $urandom, s, 6'($urandom), 2'($urandom), $urandom);
    if (sb.miss_pending) fill_line(1);
  endtask

  task automatic maint(bit [2:0] op, bit [5:0] st, bit [1:0] wy);
    send_item(op, $urandom, $urandom, 2'($urandom), st, wy, $urandom);
  endtask

  task automatic random_phase(int n);
    int stop, r;
    bit [5:0] st;
    bit [1:0] sz;
    stop = counted + n;
    while (counted < stop) begin
      r = $urandom_range(0, 99);
      st = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
      sz = ($urandom_range(0, 9) == 0) ? SZ_BAD : 2'($urandom_range(0, 2));
      if (r < 45) access(OP_READ, pick_addr(), sz);
      else if (r < 85) access(OP_WRITE, pick_addr(), sz);
      else if (r < 92) maint(OP_INVAL, st, 2'($urandom));
      else if (r < 97) maint(OP_CLEAN, st, 2'($urandom));
      else send_item(3'($urandom_range(4, 7)), $urandom, $urandom, 2'($urandom),
                     6'($urandom), 2'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    access(OP_READ, 32'h0, SZ_WORD);
    access(OP_WRITE, 32'h3, SZ_BYTE);
    access(OP_WRITE, 32'h7, SZ_HALF);
    access(OP_READ, 32'h5, SZ_HALF);
    access(OP_READ, 32'h0, SZ_BAD);
    access(OP_WRITE, 32'hFFFF_FFFF, SZ_BAD);
    access(OP_WRITE, 32'hFFFF_FFFF, SZ_WORD);
    access(OP_READ, 32'hFFFF_FFFC, SZ_BYTE);
    maint(OP_CLEAN, 6'd63, 2'd0);
    access(OP_WRITE, 32'hFFFF_FFF0, SZ_WORD);
    maint(OP_INVAL, 6'd63, 2'd0);
    maint(OP_INVAL, 6'd5, 2'd3);
    maint(OP_CLEAN, 6'd0, 2'd0);
    send_item(OP_FILL, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_item(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 6'd63, 2'd3, 32'hFFFF_FFFF);
    for (int i = 0; i < 5; i++) access(OP_WRITE, (i << 12) | 32'h40, SZ_WORD);
    drain();

    random_phase(25);
    drain();
    write_cfg(CFG_WBM, 0);
    write_cfg(CFG_IC, 1);
    random_phase(20);
    drain();
    write_cfg(CFG_WBM, 1);
    write_cfg(CFG_FWD, 0);
    random_phase(25);
    drain();
    write_cfg(CFG_WBM, 0);
    random_phase(20);
    drain();
    write_cfg(CFG_WBM, 1);
    write_cfg(CFG_FWD, 1);
    random_phase(25);

    drain();
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
